>>> rtl/core/lslf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lslf_pkg
// Shared constants, status codes and width helpers for the line fit block.
// ----------------------------------------------------------------------------
package lslf_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [1:0] {
    FIT_OK      = 2'd0,
    FIT_DEGEN   = 2'd1,
    FIT_DROPPED = 2'd2
  } fit_status_t;

  // point counter, holds 0..max_points
  function automatic int cnt_w(input int max_points);
    return $clog2(max_points + 1);
  endfunction

  // running sums of x and y
  function automatic int sx_w(input int max_points);
    return 17 + $clog2(max_points);
  endfunction

  // running sums of x*y and x*x
  function automatic int sp_w(input int max_points);
    return 32 + $clog2(max_points);
  endfunction

  function automatic int snap_w(input int max_points);
    return cnt_w(max_points) + 2 * sx_w(max_points) + 2 * sp_w(max_points) + 1;
  endfunction

  // numerator and denominator of the slope
  function automatic int num_w(input int max_points);
    int a;
    int b;
    a = cnt_w(max_points) + 1 + sp_w(max_points);
    b = 2 * sx_w(max_points);
    return ((a > b) ? a : b) + 1;
  endfunction

  // divider dividend: slope numerator scaled by 2^16, or intercept numerator / 256
  function automatic int dvd_w(input int max_points);
    int a;
    int b;
    a = num_w(max_points) + 16;
    b = 25 + sx_w(max_points);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/lslf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lslf_front
// Accepts points, keeps the count and running sums, and hands a snapshot of
// the sums to the queue on the closing point of each set.
// ----------------------------------------------------------------------------
module lslf_front
  import lslf_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            accept,
  input  wire logic signed [15:0]              x_sample,
  input  wire logic signed [15:0]              y_sample,
  input  wire logic                            last_point,
  output logic                                 push,
  output logic [snap_w(MAX_POINTS)-1:0]        snap
);

  localparam int CNT_W = cnt_w(MAX_POINTS);
  localparam int SX_W  = sx_w(MAX_POINTS);
  localparam int SP_W  = sp_w(MAX_POINTS);

  logic        [CNT_W-1:0] cnt_r, cnt_nxt;
  logic signed [SX_W-1:0]  sx_r, sx_nxt;
  logic signed [SX_W-1:0]  sy_r, sy_nxt;
  logic signed [SP_W-1:0]  sxy_r, sxy_nxt;
  logic signed [SP_W-1:0]  sxx_r, sxx_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    keep;
  logic signed [31:0]      xy;
  logic signed [31:0]      xx;

  always_comb begin
    keep    = (cnt_r < CNT_W'(MAX_POINTS));
    xy      = 32'(x_sample) * 32'(y_sample);
    xx      = 32'(x_sample) * 32'(x_sample);
    cnt_nxt = keep ? (cnt_r + CNT_W'(1)) : cnt_r;
    sx_nxt  = keep ? (sx_r + SX_W'(x_sample)) : sx_r;
    sy_nxt  = keep ? (sy_r + SX_W'(y_sample)) : sy_r;
    sxy_nxt = keep ? (sxy_r + SP_W'(xy)) : sxy_r;
    sxx_nxt = keep ? (sxx_r + SP_W'(xx)) : sxx_r;
    ovf_nxt = ovf_r | ~keep;
  end

  assign push = accept & last_point;
  assign snap = {cnt_nxt, sx_nxt, sy_nxt, sxy_nxt, sxx_nxt, ovf_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_point)) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxy_r <= '0;
      sxx_r <= '0;
      ovf_r <= 1'b0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      sxy_r <= sxy_nxt;
      sxx_r <= sxx_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS))
    else $error("point count above capacity");

endmodule
`default_nettype wire

>>> rtl/core/lslf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lslf_queue
// Short first-in first-out queue of sum snapshots between front and back.
// ----------------------------------------------------------------------------
module lslf_queue
  import lslf_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  valid,
  output logic                  full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [WIDTH-1:0] rd_data_r;

  assign valid   = (count_r != '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign rd_data = rd_data_r;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
    // hold the head word; pass the incoming word through when it lands at the head
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_ptr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      rd_ptr_r <= rd_ptr_nxt;
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("pop from an empty queue");

endmodule
`default_nettype wire

>>> rtl/core/lslf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lslf_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lslf_div #(
  parameter int DVD_W = 64,
  parameter int DSR_W = 48
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DSR_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              run_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DSR_W-1:0]  rem_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DSR_W-1:0]  dsr_r;
  logic [DSR_W:0]    trial;
  logic [DSR_W:0]    diff;

  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    diff  = trial - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= STEP_W'(DVD_W);
      end else if (run_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (run_r) begin
      // keep the trial remainder only when the divisor fits
      if (!diff[DSR_W]) begin
        rem_r <= diff[DSR_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DSR_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !run_r)
    else $error("divider restarted while running");

endmodule
`default_nettype wire

>>> rtl/core/lslf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lslf_back
// Fit engine: takes a sum snapshot, forms numerator and denominator, divides
// for slope, then intercept, saturates and emits; degenerate sets emit zeros.
// ----------------------------------------------------------------------------
module lslf_back
  import lslf_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          snap_valid,
  input  wire logic [snap_w(MAX_POINTS)-1:0] snap,
  output logic                               pop,
  output logic                               out_valid,
  output logic signed [31:0]                 out_slope,
  output logic signed [31:0]                 out_intercept,
  output logic [1:0]                         out_fit_status
);

  localparam int CNT_W = cnt_w(MAX_POINTS);
  localparam int SX_W  = sx_w(MAX_POINTS);
  localparam int SP_W  = sp_w(MAX_POINTS);
  localparam int NUM_W = num_w(MAX_POINTS);
  localparam int DVD_W = dvd_w(MAX_POINTS);
  localparam int A_W   = 33 + SX_W;
  localparam int PN_W  = CNT_W + SP_W + 1;
  localparam int PS_W  = 2 * SX_W;
  localparam int PR_W  = 32 + SX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DIFF, S_CHECK, S_SDIV, S_IMUL, S_IDIFF, S_ICHK, S_IDIV, S_OUT
  } state_t;

  state_t state_r;

  logic        [CNT_W-1:0]     s_cnt;
  logic signed [SX_W-1:0]      s_sx, s_sy;
  logic signed [SP_W-1:0]      s_sxy, s_sxx;
  logic                        s_ovf;

  logic        [CNT_W-1:0]     n_r;
  logic signed [SX_W-1:0]      sx_r, sy_r;
  logic signed [SP_W-1:0]      sxy_r, sxx_r;
  logic                        ovf_r;
  logic signed [CNT_W+SP_W:0]  p_nxy_r, p_nxx_r;
  logic signed [2*SX_W-1:0]    p_sxsy_r, p_sxsx_r;
  logic signed [NUM_W-1:0]     num_r, den_r;
  logic signed [31:0]          slope_r;
  logic signed [32+SX_W-1:0]   prod_r;
  logic signed [A_W-1:0]       a_r;
  logic                        neg_r;

  logic                        div_start_r;
  logic [DVD_W-1:0]            dividend_r;
  logic [NUM_W-1:0]            divisor_r;
  logic                        div_done;
  logic [DVD_W-1:0]            div_quo;

  logic                        out_valid_r;
  logic signed [31:0]          out_slope_r;
  logic signed [31:0]          out_icpt_r;
  fit_status_t                 out_status_r;

  logic [NUM_W-1:0]            num_mag;
  logic [A_W-1:0]              a_mag;
  logic                        q_hi;
  logic [31:0]                 q32;
  logic [31:0]                 sat_val;

  assign {s_cnt, s_sx, s_sy, s_sxy, s_sxx, s_ovf} = snap;
  assign pop = (state_r == S_IDLE) && snap_valid;

  always_comb begin
    num_mag = num_r[NUM_W-1] ? (~num_r + NUM_W'(1)) : num_r;
    a_mag   = a_r[A_W-1] ? (~a_r + A_W'(1)) : a_r;
    q_hi    = |div_quo[DVD_W-1:32];
    q32     = div_quo[31:0];
    // clamp the magnitude to the signed 32-bit range, then apply the sign
    if (neg_r) begin
      sat_val = (q_hi || (q32[31] && (|q32[30:0]))) ? 32'h8000_0000 : (~q32 + 32'd1);
    end else begin
      sat_val = (q_hi || q32[31]) ? 32'h7FFF_FFFF : q32;
    end
  end

  lslf_div #(
    .DVD_W (DVD_W),
    .DSR_W (NUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (dividend_r),
    .divisor  (divisor_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (snap_valid) begin
            n_r     <= s_cnt;
            sx_r    <= s_sx;
            sy_r    <= s_sy;
            sxy_r   <= s_sxy;
            sxx_r   <= s_sxx;
            ovf_r   <= s_ovf;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          p_nxy_r  <= PN_W'($signed({1'b0, n_r})) * PN_W'(sxy_r);
          p_nxx_r  <= PN_W'($signed({1'b0, n_r})) * PN_W'(sxx_r);
          p_sxsy_r <= PS_W'(sx_r) * PS_W'(sy_r);
          p_sxsx_r <= PS_W'(sx_r) * PS_W'(sx_r);
          state_r  <= S_DIFF;
        end
        S_DIFF: begin
          num_r   <= NUM_W'(p_nxy_r) - NUM_W'(p_sxsy_r);
          den_r   <= NUM_W'(p_nxx_r) - NUM_W'(p_sxsx_r);
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if ((den_r == '0) || (n_r == '0)) begin
            out_slope_r  <= '0;
            out_icpt_r   <= '0;
            out_status_r <= FIT_DEGEN;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end else begin
            dividend_r  <= DVD_W'({num_mag, 16'h0000});
            divisor_r   <= den_r;
            neg_r       <= num_r[NUM_W-1];
            div_start_r <= 1'b1;
            state_r     <= S_SDIV;
          end
        end
        S_SDIV: begin
          if (div_done) begin
            slope_r <= sat_val;
            state_r <= S_IMUL;
          end
        end
        S_IMUL: begin
          prod_r  <= PR_W'(slope_r) * PR_W'(sx_r);
          state_r <= S_IDIFF;
        end
        S_IDIFF: begin
          a_r     <= A_W'($signed({sy_r, 16'h0000})) - A_W'(prod_r);
          state_r <= S_ICHK;
        end
        S_ICHK: begin
          // divide by 256*n as a shift by 8 and then a divide by n
          dividend_r  <= DVD_W'(a_mag[A_W-1:8]);
          divisor_r   <= NUM_W'(n_r);
          neg_r       <= a_r[A_W-1];
          div_start_r <= 1'b1;
          state_r     <= S_IDIV;
        end
        S_IDIV: begin
          if (div_done) begin
            out_icpt_r <= sat_val;
            state_r    <= S_OUT;
          end
        end
        S_OUT: begin
          out_slope_r  <= slope_r;
          out_status_r <= ovf_r ? FIT_DROPPED : FIT_OK;
          out_valid_r  <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_slope      = out_slope_r;
  assign out_intercept  = out_icpt_r;
  assign out_fit_status = out_status_r;

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == FIT_DEGEN)) |-> ((out_slope_r == '0) && (out_icpt_r == '0)))
    else $error("degenerate fit with non-zero results");

endmodule
`default_nettype wire

>>> rtl/core/least_squares_line_fit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// least_squares_line_fit
// Straight-line least-squares fit over sets of signed Q8.8 points.
//
//   channel  ports                                         handshake
//   input    in_x_sample, in_y_sample, in_last_point       start & !busy
//   result   out_slope, out_intercept, out_fit_status      out_valid strobe
//
// A point is accumulated in the cycle it is accepted; busy rises only while
// the snapshot queue is full, so points stream in one per cycle while busy is low.
// A set's fit runs in the back end, which takes a new snapshot only when idle;
// slope and intercept go through the shared one-bit-per-cycle divider.
// Reset is synchronous and active low; it clears all sums and the queue.
// The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module least_squares_line_fit
  import lslf_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] in_x_sample,
  input  wire logic signed [15:0] in_y_sample,
  input  wire logic               in_last_point,
  output logic                    out_valid,
  output logic signed [31:0]      out_slope,
  output logic signed [31:0]      out_intercept,
  output logic [1:0]              out_fit_status
);

  localparam int SNAP_W = snap_w(MAX_POINTS);

  logic              accept;
  logic              push;
  logic [SNAP_W-1:0] push_data;
  logic              pop;
  logic [SNAP_W-1:0] pop_data;
  logic              q_valid;
  logic              q_full;

  assign busy   = q_full;
  assign accept = start & ~q_full;

  lslf_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .x_sample   (in_x_sample),
    .y_sample   (in_y_sample),
    .last_point (in_last_point),
    .push       (push),
    .snap       (push_data)
  );

  lslf_queue #(
    .WIDTH (SNAP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_data),
    .pop     (pop),
    .rd_data (pop_data),
    .valid   (q_valid),
    .full    (q_full)
  );

  lslf_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .snap_valid     (q_valid),
    .snap           (pop_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_slope      (out_slope),
    .out_intercept  (out_intercept),
    .out_fit_status (out_fit_status)
  );

endmodule
`default_nettype wire

>>> sim/tb_least_squares_line_fit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_least_squares_line_fit
// Self-checking bench for the least-squares line fit block. Point words are
// sent through the start/busy handshake. A small scoreboard keeps its own
// running sums and predicts slope, intercept and status for every closed set.
// Each strobed result word is checked against the oldest prediction. Stimulus
// is a short directed run followed by random sets in phases of sender idling.
// ----------------------------------------------------------------------------
module tb_least_squares_line_fit
  import lslf_pkg::*;
();

  localparam int KEEP_MAX     = MAX_POINTS_DEF;
  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_CYCLES = 200;
  localparam longint LIMIT_CYCLES = 2_000_000;

  typedef struct {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    fit_status_t        status;
  } fit_word_t;

  class line_fit_scoreboard;
    int unsigned kept;
    longint      sum_x;
    longint      sum_y;
    longint      sum_xy;
    longint      sum_xx;
    bit          dropped;
    fit_word_t   pending[$];
    int unsigned errors;

    function void clear_sums();
      kept    = 0;
      sum_x   = 0;
      sum_y   = 0;
      sum_xy  = 0;
      sum_xx  = 0;
      dropped = 1'b0;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Fold one accepted point into the sums; on the closing point predict the fit.
    function void note_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
      longint    xv;
      longint    yv;
      longint    n;
      longint    num;
      longint    den;
      longint    quo;
      longint    rem;
      longint    slope;
      longint    icpt;
      fit_word_t w;
      xv = longint'(x);
      yv = longint'(y);
      if (kept < KEEP_MAX) begin
        kept++;
        sum_x  += xv;
        sum_y  += yv;
        sum_xy += xv * yv;
        sum_xx += xv * xv;
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;
      n     = longint'(kept);
      num   = n * sum_xy - sum_x * sum_y;
      den   = n * sum_xx - sum_x * sum_x;
      slope = 0;
      icpt  = 0;
      if (den <= 0 || n == 0) begin
        w.status = FIT_DEGEN;
      end else begin
        quo = num / den;
        rem = num % den;
        if (quo > 65536) slope = 64'sd2147483647;
        else if (quo < -65536) slope = -64'sd2147483648;
        else slope = clamp32(quo * 65536 + (rem * 65536) / den);
        // intercept uses the slope as reported, already truncated and clamped
        icpt = clamp32((sum_y * 65536 - slope * sum_x) / (n * 256));
        w.status = dropped ? FIT_DROPPED : FIT_OK;
      end
      w.slope     = slope[31:0];
      w.intercept = icpt[31:0];
      pending.push_back(w);
      clear_sums();
    endfunction

    function void check_result(logic signed [31:0] slope, logic signed [31:0] intercept,
                               logic [1:0] status);
      fit_word_t w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: slope %0d intercept %0d status %0d",
                   slope, intercept, status);
        return;
      end
      w = pending.pop_front();
      if (slope !== w.slope || intercept !== w.intercept || status !== w.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected slope %0d intercept %0d status %0d, got %0d %0d %0d",
                   w.slope, w.intercept, w.status, slope, intercept, status);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [15:0] in_x_sample;
  logic signed [15:0] in_y_sample;
  logic               in_last_point;
  logic               out_valid;
  logic signed [31:0] out_slope;
  logic signed [31:0] out_intercept;
  logic [1:0]         out_fit_status;

  line_fit_scoreboard sb;
  int                 idle_pct;
  int                 random_sent;

  least_squares_line_fit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_x_sample    (in_x_sample),
    .in_y_sample    (in_y_sample),
    .in_last_point  (in_last_point),
    .out_valid      (out_valid),
    .out_slope      (out_slope),
    .out_intercept  (out_intercept),
    .out_fit_status (out_fit_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      sb.check_result(out_slope, out_intercept, out_fit_status);
  end

  // Offer one point word, idling first at the current rate, and hold it until taken.
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic last);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start         <= 1'b1;
    in_x_sample   <= x;
    in_y_sample   <= y;
    in_last_point <= last;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_point(x, y, last);
  endtask

  // Drop start and wait until every predicted fit has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_set();
    int                 len;
    int                 pick;
    int                 mode;
    int                 k;
    int                 base;
    int                 yv;
    int                 i;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] x_fixed;
    pick = $urandom_range(99);
    if (pick < 5) len = 1;
    else if (pick < 75) len = $urandom_range(8, 2);
    else if (pick < 90) len = $urandom_range(16, 9);
    else len = $urandom_range(22, 17);
    pick = $urandom_range(99);
    if (pick < 55) mode = 1;
    else if (pick < 75) mode = 0;
    else if (pick < 87) mode = 3;
    else mode = 2;
    k       = $urandom_range(16, 0) - 8;
    base    = $urandom_range(4000, 0) - 2000;
    x_fixed = 16'($urandom);
    for (i = 0; i < len; i++) begin
      case (mode)
        0: begin
          x = 16'($urandom);
          y = 16'($urandom);
        end
        1: begin
          if ($urandom_range(1)) x = 16'($urandom);
          else x = 16'($urandom_range(2000, 0) - 1000);
          // line of slope k/4 plus a little noise, clipped to the Q8.8 range
          yv = (int'(x) * k) / 4 + base + int'($urandom_range(64, 0)) - 32;
          if (yv > 32767) yv = 32767;
          if (yv < -32768) yv = -32768;
          y = 16'(yv);
        end
        2: begin
          x = x_fixed;
          y = 16'($urandom);
        end
        default: begin
          x = 16'($urandom_range(8, 0) - 4);
          y = 16'($urandom_range(8, 0) - 4);
        end
      endcase
      send_point(x, y, i == len - 1);
    end
    random_sent += (len < KEEP_MAX) ? len : KEEP_MAX;
  endtask

  task automatic run_phase(input int pct, input int items);
    idle_pct    = pct;
    random_sent = 0;
    while (random_sent < items) send_random_set();
    drain();
  endtask

  initial begin
    int i;
    sb = new;
    sb.clear_sums();
    sb.errors = 0;
    idle_pct  = 0;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_x_sample   <= '0;
    in_y_sample   <= '0;
    in_last_point <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single point: degenerate
    send_point(16'sd300, -16'sd200, 1'b1);
    // field extremes
    send_point(-16'sd32768, -16'sd32768, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b1);
    // all x equal: degenerate
    send_point(16'sd100, 16'sd5, 1'b0);
    send_point(16'sd100, -16'sd7, 1'b1);
    // steepest rise and fall: slope clamps
    send_point(16'sd0, -16'sd32768, 1'b0);
    send_point(16'sd1, 16'sd32767, 1'b1);
    send_point(-16'sd32768, 16'sd32767, 1'b0);
    send_point(-16'sd32767, -16'sd32768, 1'b1);
    // past capacity, closing point dropped as well
    for (i = 0; i < KEEP_MAX + 2; i++)
      send_point(16'(i * 64 - 500), 16'(i * 40 + 77), i == KEEP_MAX + 1);
    drain();

    run_phase(0, RANDOM_ITEMS / 3);
    run_phase(68, RANDOM_ITEMS / 3);
    run_phase(25, RANDOM_ITEMS / 3);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lslf_pkg.sv
rtl/core/lslf_front.sv
rtl/core/lslf_queue.sv
rtl/core/lslf_div.sv
rtl/core/lslf_back.sv
rtl/core/least_squares_line_fit.sv
sim/tb_least_squares_line_fit.sv
